// ----- rtl/tcb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants of the text cell buffer
// Operation codes, register indexes, item and result layouts.
// ----------------------------------------------------------------------------
package tcb_pkg;

    // Operation codes; code three means nothing and is dropped
    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_FILL = 2'd2
    } op_t;

    // Configuration register indexes
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 8;
    localparam logic [1:0]  CFG_COLOR  = 2'd0;
    localparam logic [1:0]  CFG_COLS   = 2'd1;
    localparam logic [1:0]  CFG_ROWS   = 2'd2;

    localparam logic [7:0]  COLOR_RST  = 8'd0;
    localparam logic [7:0]  COLS_RST   = 8'd128;
    localparam logic [6:0]  ROWS_RST   = 7'd64;

    // One stored cell: color in the high byte, glyph in the low byte
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] glyph;
    } cell_t;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [7:0]         rect_height;
        logic [7:0]         rect_width;
        logic [7:0]         glyph_in;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
        logic [1:0]         operation;
    } item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic       on_screen;
        logic [7:0] cell_color;
        logic [7:0] cell_glyph;
    } result_t;

    localparam int ITEM_W     = $bits(item_t);
    localparam int RESULT_W   = $bits(result_t);
    localparam int S_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// ----- rtl/tcb_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_store: cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcb_store #(
    parameter int DEPTH = 8192,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  tcb_pkg::cell_t    wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output tcb_pkg::cell_t    rd_data
);
    import tcb_pkg::*;

    cell_t mem [0:DEPTH-1];
    cell_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tcb_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_seq: operation sequencer
// Clears the store after reset, decodes items, clips positions and
// rectangles, drives the memory and walks fills one cell per cycle.
// ----------------------------------------------------------------------------
module tcb_seq #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    localparam int DEPTH  = MAX_COLS * MAX_ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CCNT_W = $clog2(MAX_COLS + 1),
    localparam int RCNT_W = $clog2(MAX_ROWS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                item_ready,
    input  tcb_pkg::item_t      item,
    input  logic [CCNT_W-1:0]   eff_cols,
    input  logic [RCNT_W-1:0]   eff_rows,
    input  logic [7:0]          color,
    output logic                mem_wr_en,
    output logic [ADDR_W-1:0]   mem_wr_addr,
    output tcb_pkg::cell_t      mem_wr_data,
    output logic                mem_rd_en,
    output logic [ADDR_W-1:0]   mem_rd_addr,
    input  tcb_pkg::cell_t      mem_rd_data,
    input  logic                out_free,
    output logic                res_load,
    output tcb_pkg::result_t    res
);
    import tcb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_PUT,
        S_GET,
        S_RESP,
        S_FILL
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    item_t               item_reg, item_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CCNT_W-1:0]   col_reg, col_next;
    logic [RCNT_W-1:0]   row_reg, row_next;
    logic [CCNT_W-1:0]   x0_reg, x0_next;
    logic [CCNT_W-1:0]   x1_reg, x1_next;
    logic [RCNT_W-1:0]   y1_reg, y1_next;
    logic                on_reg, on_next;

    logic signed [17:0]  x_s, y_s, x0_s, y0_s, x1_raw, y1_raw, x1_s, y1_s;
    logic signed [17:0]  cols_s, rows_s;
    logic                on_x, on_y, nonempty;
    logic [ADDR_W-1:0]   mult_full;
    logic [ADDR_W-1:0]   cell_addr;
    logic [CCNT_W-1:0]   col_inc;
    logic [RCNT_W-1:0]   row_inc;

    // Clip the registered item against the screen
    always_comb begin
        x_s    = 18'(item_reg.pos_x);
        y_s    = 18'(item_reg.pos_y);
        cols_s = 18'(eff_cols);
        rows_s = 18'(eff_rows);
        x0_s   = x_s[17] ? '0 : x_s;
        y0_s   = y_s[17] ? '0 : y_s;
        x1_raw = x_s + 18'(item_reg.rect_width);
        y1_raw = y_s + 18'(item_reg.rect_height);
        x1_s   = (x1_raw > cols_s) ? cols_s : x1_raw;
        y1_s   = (y1_raw > rows_s) ? rows_s : y1_raw;
        on_x   = !x_s[17] && (x_s < cols_s);
        on_y   = !y_s[17] && (y_s < rows_s);
        nonempty = (x0_s < x1_s) && (y0_s < y1_s);
        // Row base of an on-screen row always fits the address width
        mult_full = ADDR_W'(y0_s[ROW_W-1:0]) * ADDR_W'(eff_cols);
    end

    assign cell_addr = base_reg + ADDR_W'(col_reg);
    assign col_inc   = col_reg + 1'b1;
    assign row_inc   = row_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        item_next  = item_reg;
        base_next  = base_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        on_next    = on_reg;
        item_ready = 1'b0;
        mem_wr_en  = 1'b0;
        mem_wr_addr = cell_addr;
        mem_wr_data = {color, item_reg.glyph_in};
        mem_rd_en  = 1'b0;
        mem_rd_addr = cell_addr;
        res_load   = 1'b0;
        res.on_screen  = on_reg;
        res.cell_glyph = on_reg ? mem_rd_data.glyph : 8'd0;
        res.cell_color = on_reg ? mem_rd_data.color : 8'd0;

        case (state_reg)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    item_next  = item;
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                base_next = mult_full;
                col_next  = x0_s[CCNT_W-1:0];
                row_next  = y0_s[RCNT_W-1:0];
                x0_next   = x0_s[CCNT_W-1:0];
                x1_next   = x1_s[CCNT_W-1:0];
                y1_next   = y1_s[RCNT_W-1:0];
                on_next   = on_x && on_y;
                case (item_reg.operation)
                    OP_PUT:  state_next = (on_x && on_y) ? S_PUT : S_IDLE;
                    OP_GET:  state_next = S_GET;
                    OP_FILL: state_next = nonempty ? S_FILL : S_IDLE;
                    default: state_next = S_IDLE;
                endcase
            end
            S_PUT: begin
                mem_wr_en  = 1'b1;
                state_next = S_IDLE;
            end
            S_GET: begin
                mem_rd_en  = on_reg;
                state_next = S_RESP;
            end
            S_RESP: begin
                // Hold the read word until the output register frees up
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FILL: begin
                mem_wr_en = 1'b1;
                if (col_inc == x1_reg) begin
                    if (row_inc == y1_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        col_next  = x0_reg;
                        row_next  = row_inc;
                        base_next = base_reg + ADDR_W'(eff_cols);
                    end
                end else begin
                    col_next = col_inc;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        item_reg <= item_next;
        base_reg <= base_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        on_reg   <= on_next;
    end

endmodule

// ----- rtl/text_cell_buffer_clip_fill_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_buffer_clip_fill_core: character-cell screen store
// Put, get and clipped rectangle fill over a glyph/color cell memory.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as transfers on the s_ channel (put, get, fill). Only a
//   get returns a transfer on the m_ channel: the cell's glyph and color and
//   an on-screen flag (glyph and color read as zero off screen). Off-screen
//   puts and the unused operation code are dropped without a result.
//   The config port sets the current color and the columns and rows in use;
//   write it only while no command is in flight.
// Sequencing (one command at a time, set by the sequencer):
//   put  address multiply, then memory write
//   get  multiply, registered memory read, output register load
//   fill address multiply, then one write per clipped cell (one write port)
// Reset: aresetn is synchronous. After release the block sweeps the whole
//   cell memory to zero, one entry a cycle (MAX_COLS*MAX_ROWS entries, 8192
//   with the defaults), with s_tready low; config writes are taken meanwhile.
// Stall: a held result sits in the output register. Further puts and fills
//   are taken; the next get waits until the register is free.
// ----------------------------------------------------------------------------
module text_cell_buffer_clip_fill_core #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Command stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[1:0], pos_x[17:2], pos_y[33:18], glyph_in[41:34],
    // rect_width[49:42], rect_height[57:50], zero pad above
    input  logic [tcb_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_glyph[7:0], cell_color[15:8], on_screen[16], zero pad above
    output logic [tcb_pkg::M_TDATA_W-1:0]     m_tdata,
    // Config write port
    input  logic                              cfg_wr_en,
    input  logic [tcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcb_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import tcb_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    // Config registers
    logic [7:0] color_reg;
    logic [7:0] cols_reg;
    logic [6:0] rows_reg;

    logic [CCNT_W-1:0] eff_cols;
    logic [RCNT_W-1:0] eff_rows;

    // Memory port wires
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    cell_t             mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    cell_t             mem_rd_data;

    // Output register
    logic              m_valid_reg;
    result_t           m_data_reg;
    logic              out_free;
    logic              res_load;
    result_t           res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= COLOR_RST;
            cols_reg  <= COLS_RST;
            rows_reg  <= ROWS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COLOR: color_reg <= cfg_wr_data;
                CFG_COLS:  cols_reg  <= cfg_wr_data;
                CFG_ROWS:  rows_reg  <= cfg_wr_data[6:0];
                default:   ;
            endcase
        end
    end

    // Clamp the screen size to the memory geometry
    assign eff_cols = (16'(cols_reg) > 16'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_reg);
    assign eff_rows = (16'(rows_reg) > 16'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_reg);

    tcb_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item        (item_t'(s_tdata[ITEM_W-1:0])),
        .eff_cols    (eff_cols),
        .eff_rows    (eff_rows),
        .color       (color_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    tcb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_load) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // One command at a time: no transfer right after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted in the cycle after another");

    // Memory writes happen only while the sequencer is busy
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> !s_tready)
        else $error("memory write while accepting commands");

    // Off-screen results carry zero glyph and color
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.on_screen) |->
            (m_data_reg.cell_glyph == 8'd0 && m_data_reg.cell_color == 8'd0))
        else $error("off-screen result with nonzero cell");

    // A result load never overwrites one that is still held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while stalled");

endmodule

// ----- tb/sv/tcb_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_tb_pkg: screen mirror for the text cell buffer testbench
// Keeps a copy of the cell memory and registers, predicts get read-backs
// and compares them with what the block returns.
// ----------------------------------------------------------------------------
package tcb_tb_pkg;

    import tcb_pkg::*;

    localparam int MIRROR_COLS = 128;
    localparam int MIRROR_ROWS = 64;

    class screen_mirror;

        cell_t      cells [MIRROR_COLS*MIRROR_ROWS];
        logic [7:0] color;
        logic [7:0] cols;
        logic [6:0] rows;
        result_t    read_backs [$];
        int         errors;
        int         settle_cycles;  // cycles the last command may still keep the block busy

        function new();
            foreach (cells[i]) cells[i] = '0;
            color         = COLOR_RST;
            cols          = COLS_RST;
            rows          = ROWS_RST;
            errors        = 0;
            settle_cycles = 8;
        endfunction

        function void configure(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_COLOR: color = data;
                CFG_COLS:  cols  = data;
                CFG_ROWS:  rows  = data[6:0];
                default: ;
            endcase
        endfunction

        function int cols_in_use();
            return (int'(cols) > MIRROR_COLS) ? MIRROR_COLS : int'(cols);
        endfunction

        function int rows_in_use();
            return (int'(rows) > MIRROR_ROWS) ? MIRROR_ROWS : int'(rows);
        endfunction

        function bit visible(int x, int y);
            return x >= 0 && y >= 0 && x < cols_in_use() && y < rows_in_use();
        endfunction

        function void put_cell(int x, int y, logic [7:0] glyph);
            if (visible(x, y)) begin
                cells[x + y * cols_in_use()] = {color, glyph};
            end
        endfunction

        function int outstanding();
            return read_backs.size();
        endfunction

        // Apply one accepted command to the mirror
        function void note_command(item_t it);
            int      x, y, w, h, x0, y0, x1, y1, n;
            result_t r;
            cell_t   c;
            x = int'(it.pos_x);
            y = int'(it.pos_y);
            w = int'(it.rect_width);
            h = int'(it.rect_height);
            settle_cycles = 8;
            case (it.operation)
                OP_PUT: put_cell(x, y, it.glyph_in);
                OP_GET: begin
                    r = '0;
                    if (visible(x, y)) begin
                        c            = cells[x + y * cols_in_use()];
                        r.cell_glyph = c.glyph;
                        r.cell_color = c.color;
                        r.on_screen  = 1'b1;
                    end
                    read_backs.push_back(r);
                end
                OP_FILL: begin
                    x0 = (x < 0) ? 0 : x;
                    y0 = (y < 0) ? 0 : y;
                    x1 = (x + w > cols_in_use()) ? cols_in_use() : x + w;
                    y1 = (y + h > rows_in_use()) ? rows_in_use() : y + h;
                    n  = 0;
                    for (int i = x0; i < x1; i++) begin
                        for (int j = y0; j < y1; j++) begin
                            put_cell(i, j, it.glyph_in);
                            n++;
                        end
                    end
                    settle_cycles = n + 8;
                end
                default: ;
            endcase
        endfunction

        // Compare one returned transfer with the oldest predicted read-back
        function void check_read_back(result_t got);
            result_t want;
            if (read_backs.size() == 0) begin
                errors++;
                $display("%0t: read-back with none pending, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = read_backs.pop_front();
            if (got.cell_glyph !== want.cell_glyph) begin
                errors++;
                $display("%0t: cell_glyph expected %h actual %h",
                         $time, want.cell_glyph, got.cell_glyph);
            end
            if (got.cell_color !== want.cell_color) begin
                errors++;
                $display("%0t: cell_color expected %h actual %h",
                         $time, want.cell_color, got.cell_color);
            end
            if (got.on_screen !== want.on_screen) begin
                errors++;
                $display("%0t: on_screen expected %b actual %b",
                         $time, want.on_screen, got.on_screen);
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_text_cell_buffer_clip_fill_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_cell_buffer_clip_fill_core: self-checking bench of the cell buffer
// Drives put, get, fill and unused-code commands, directed then random, over several
// screen geometries and colors, mirrors the cell memory and checks every
// get read-back field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_text_cell_buffer_clip_fill_core;

    import tcb_pkg::*;
    import tcb_tb_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;   // dropped by the block
    localparam int         PHASES      = 10;
    localparam int         PHASE_ITEMS = 130;
    localparam int         HOLD_CYCLES = 400;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    // operation, pos_x, pos_y, glyph_in, rect_width, rect_height, zero pad
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // cell_glyph, cell_color, on_screen, zero pad
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;

    screen_mirror            mirror;

    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    bit                      hold_req       = 1'b0;
    int                      hold_left      = 0;
    int                      large_left     = 16;  // budget of slow big fills not pushed off screen
    logic signed [15:0]      last_x         = '0;
    logic signed [15:0]      last_y         = '0;

    text_cell_buffer_clip_fill_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit: far beyond the slowest correct run (clear sweep, every big
    // fill at full screen, every read-back under the longest stall)
    initial begin
        #100ms;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready changes at the falling edge, transfers are taken at
    // the rising edge. A long hold-off is counted here once requested.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (aresetn && m_tvalid && m_tready) begin
            mirror.check_read_back(result_t'(m_tdata[RESULT_W-1:0]));
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    function automatic item_t make_cmd(logic [1:0] op, int x, int y, logic [7:0] glyph,
                                       logic [7:0] w, logic [7:0] h);
        item_t it;
        it.operation   = op;
        it.pos_x       = 16'(x);
        it.pos_y       = 16'(y);
        it.glyph_in    = glyph;
        it.rect_width  = w;
        it.rect_height = h;
        return it;
    endfunction

    // Mostly on screen, some just around the edges, a few anywhere
    function automatic logic signed [15:0] pick_coord(int lim);
        int r;
        r = $urandom_range(99);
        if (lim == 0 || r < 6) return 16'($urandom);
        if (r < 20) return 16'(int'($urandom_range(0, lim + 3)) - 3);
        return 16'($urandom_range(0, lim - 1));
    endfunction

    function automatic item_t random_cmd();
        item_t it;
        int    r;
        it.glyph_in    = 8'($urandom);
        it.rect_width  = 8'($urandom_range(0, 7));
        it.rect_height = 8'($urandom_range(0, 7));
        it.pos_x       = pick_coord(mirror.cols_in_use());
        it.pos_y       = pick_coord(mirror.rows_in_use());
        r = $urandom_range(99);
        if (r < 40) begin
            it.operation = OP_PUT;
        end else if (r < 75) begin
            it.operation = OP_GET;
            // read back recently written cells half of the time
            if ($urandom_range(1)) begin
                it.pos_x = last_x;
                it.pos_y = last_y;
            end
        end else if (r < 95) begin
            it.operation = OP_FILL;
            if ($urandom_range(9) == 0) begin
                it.rect_width  = 8'($urandom);
                it.rect_height = 8'($urandom);
                // once the budget is spent, push big fills off screen to the left
                if (large_left > 0) large_left--;
                else it.pos_x = -16'sd300;
            end
        end else begin
            it.operation = OP_UNUSED;
        end
        if (it.operation == OP_PUT || it.operation == OP_FILL) begin
            last_x = it.pos_x;
            last_y = it.pos_y;
        end
        return it;
    endfunction

    // Offer one command from a falling edge; return on the falling edge after
    // the transfer with valid still high
    task automatic send_item(item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W-ITEM_W){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
        mirror.note_command(it);
        @(negedge aclk);
    endtask

    // Drop valid, wait out every pending read-back, then let the last
    // command finish its memory work
    task automatic settle();
        s_tvalid = 1'b0;
        while (mirror.outstanding() != 0) @(negedge aclk);
        repeat (mirror.settle_cycles) @(negedge aclk);
    endtask

    task automatic write_settings(logic [7:0] color, logic [7:0] cols, logic [7:0] rows);
        cfg_wr_en   = 1'b1;
        cfg_index   = CFG_COLOR;
        cfg_wr_data = color;
        @(negedge aclk);
        cfg_index   = CFG_COLS;
        cfg_wr_data = cols;
        @(negedge aclk);
        cfg_index   = CFG_ROWS;
        cfg_wr_data = rows;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        mirror.configure(CFG_COLOR, color);
        mirror.configure(CFG_COLS, cols);
        mirror.configure(CFG_ROWS, rows);
    endtask

    initial begin
        int   cols_tab [PHASES];
        int   rows_tab [PHASES];
        logic [7:0] color;

        mirror      = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_COLOR;
        cfg_wr_data = '0;

        // geometries: full, single cell, zero, above the maximum, odd sizes
        cols_tab = '{128, 1, 128, 80, 0, 255, 13, 40, 128, 7};
        rows_tab = '{64,  1, 64,  25, 0, 127, 64, 30, 1,   5};

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset settings; the block holds ready low
        // during its clearing sweep, so the first transfer simply waits
        send_item(make_cmd(OP_GET,  0, 0, 8'h00, 8'd0, 8'd0));        // cleared cell
        send_item(make_cmd(OP_GET,  127, 63, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_PUT,  0, 0, 8'hFF, 8'd0, 8'd0));
        send_item(make_cmd(OP_PUT,  127, 63, 8'h01, 8'd0, 8'd0));
        send_item(make_cmd(OP_GET,  0, 0, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_GET,  127, 63, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_PUT,  128, 0, 8'h33, 8'd0, 8'd0));      // off screen, dropped
        send_item(make_cmd(OP_PUT,  -1, 5, 8'h44, 8'd0, 8'd0));
        send_item(make_cmd(OP_GET,  128, 0, 8'h00, 8'd0, 8'd0));      // off-screen read
        send_item(make_cmd(OP_GET,  0, 64, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_GET,  -32768, 32767, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_cmd(OP_GET,  32767, -32768, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_FILL, -2, -2, 8'h7E, 8'd5, 8'd4));      // clipped at the corner
        send_item(make_cmd(OP_FILL, 10, 10, 8'h11, 8'd0, 8'd5));      // zero width
        send_item(make_cmd(OP_FILL, 10, 10, 8'h22, 8'd5, 8'd0));      // zero height
        send_item(make_cmd(OP_GET,  2, 1, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_GET,  10, 10, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_UNUSED, 3, 3, 8'hC3, 8'h80, 8'h80));    // unused code
        send_item(make_cmd(OP_FILL, 120, 60, 8'h55, 8'd255, 8'd255)); // runs off both edges
        send_item(make_cmd(OP_FILL, 200, 0, 8'h66, 8'd4, 8'd4));      // wholly off screen
        send_item(make_cmd(OP_GET,  127, 63, 8'h00, 8'd0, 8'd0));
        send_item(make_cmd(OP_PUT,  5, 5, 8'hAA, 8'd0, 8'd0));
        send_item(make_cmd(OP_GET,  5, 5, 8'h00, 8'd0, 8'd0));

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                1:       color = 8'h00;
                2:       color = 8'hFF;
                default: color = 8'($urandom);
            endcase
            write_settings(color, 8'(cols_tab[ph]), 8'(rows_tab[ph]));

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase

            // Hold the result side off while gets keep coming, so the output
            // register fills and the block stalls its command input
            if (ph == 2) begin
                hold_req = 1'b1;
                for (int k = 0; k < 24; k++) begin
                    send_item(make_cmd((k % 3 == 0) ? OP_PUT : OP_GET,
                                       $urandom_range(0, 7), $urandom_range(0, 3),
                                       8'($urandom), 8'd0, 8'd0));
                end
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // pause mid-phase until every read-back has come home
                if (ph == 5 && k == PHASE_ITEMS / 2) begin
                    s_tvalid = 1'b0;
                    while (mirror.outstanding() != 0) @(negedge aclk);
                end
                send_item(random_cmd());
            end
        end

        settle();
        if (mirror.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
